[rtl/pslb_pkg.sv]
`timescale 1ns / 1ps

package pslb_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned EVENT_W    = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned NUM_FLAGS  = 8;
    localparam int unsigned PHASE_W    = 10;
    localparam int unsigned PAUSE_W    = 15;
    localparam int unsigned FLASH_W    = 2;

    localparam logic [COLOR_W-1:0] SCALE_RESET = COLOR_W'(13);

    typedef logic [EVENT_W-1:0] event_t;

    localparam event_t NO_EVENT = EVENT_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_PULSE = 2'd3
    } command_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [PHASE_W-1:0] on_ms;
        logic [PHASE_W-1:0] off_ms;
        logic [FLASH_W-1:0] flashes;
        logic [PAUSE_W-1:0] pause_ms;
        logic               repeat_en;
    } pattern_t;

    typedef struct packed {
        logic               has_event;
        event_t             current_event;
        logic               color_write;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
    } result_t;

    function automatic pattern_t blink_pattern(input event_t ev);
        pattern_t p;
        unique case (ev)
            4'd0:    p = '{8'd0,   8'd120, 8'd255, 10'd120,  10'd880,  2'd2, 15'd5000,  1'b1};
            4'd1:    p = '{8'd160, 8'd0,   8'd200, 10'd250,  10'd250,  2'd2, 15'd2000,  1'b1};
            4'd2:    p = '{8'd255, 8'd80,  8'd0,   10'd200,  10'd200,  2'd1, 15'd5000,  1'b1};
            4'd3:    p = '{8'd255, 8'd255, 8'd255, 10'd100,  10'd100,  2'd2, 15'd1000,  1'b1};
            4'd4:    p = '{8'd0,   8'd120, 8'd255, 10'd100,  10'd100,  2'd2, 15'd1000,  1'b1};
            4'd5:    p = '{8'd140, 8'd0,   8'd255, 10'd1000, 10'd1000, 2'd1, 15'd0,     1'b1};
            4'd6:    p = '{8'd255, 8'd140, 8'd0,   10'd150,  10'd150,  2'd3, 15'd10000, 1'b1};
            4'd7:    p = '{8'd0,   8'd80,  8'd255, 10'd150,  10'd150,  2'd1, 15'd30000, 1'b1};
            default: p = '{8'd0,   8'd200, 8'd200, 10'd150,  10'd150,  2'd2, 15'd0,     1'b0};
        endcase
        return p;
    endfunction

    // Exact floor(v * s / 255) for any 8-bit v and s.
    function automatic logic [COLOR_W-1:0] scale_channel(
        input logic [COLOR_W-1:0] v,
        input logic [COLOR_W-1:0] s
    );
        logic [2*COLOR_W-1:0] prod;
        logic [2*COLOR_W:0]   sum;
        prod = (2*COLOR_W)'(v) * (2*COLOR_W)'(s);
        sum  = (2*COLOR_W+1)'(prod) + (2*COLOR_W+1)'(prod >> COLOR_W)
             + (2*COLOR_W+1)'(1);
        return sum[2*COLOR_W-1:COLOR_W];
    endfunction

endpackage

[rtl/priority_status_led_blinker.sv]
`timescale 1ns / 1ps

// Priority status LED blinker. Each request is a start, stop or firmware-check pulse that
// updates the status flags, or a tick that steps the blink pattern of the highest-priority
// active event and may write a scaled overlay color. Every request yields exactly one result.
// The block takes one request per clock cycle while its result buffer is not full; a request
// is held in the input register once accepted, and its blink update (32-bit elapsed-time
// compare and three 8x8 color scaling multipliers) is then captured in the result register
// or the skid entry. A two-entry result buffer lets requests keep flowing while a result
// waits. The brightness scale should only be written while no request is in flight.
module priority_status_led_blinker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pslb_pkg::COLOR_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pslb_pkg::CMD_W-1:0]        s_command,
    input  logic [pslb_pkg::EVENT_W-1:0]      s_event_code,
    input  logic [pslb_pkg::TIME_W-1:0]       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_has_event,
    output logic [pslb_pkg::EVENT_W-1:0]      m_current_event,
    output logic                              m_color_write,
    output logic [pslb_pkg::COLOR_W-1:0]      m_red_out,
    output logic [pslb_pkg::COLOR_W-1:0]      m_green_out,
    output logic [pslb_pkg::COLOR_W-1:0]      m_blue_out
);

    logic                              in_valid_reg;
    logic [pslb_pkg::CMD_W-1:0]        in_command_reg;
    pslb_pkg::event_t                  in_code_reg;
    logic [pslb_pkg::TIME_W-1:0]       in_now_reg;

    logic [pslb_pkg::COLOR_W-1:0]      scale_reg;
    logic [pslb_pkg::NUM_FLAGS-1:0]    event_flags_reg;
    logic                              pulse_reg;
    pslb_pkg::event_t                  shown_event_reg;
    logic                              lamp_on_reg;
    logic [pslb_pkg::TIME_W-1:0]       last_toggle_reg;
    logic [pslb_pkg::FLASH_W-1:0]      flash_count_reg;
    logic [pslb_pkg::TIME_W-1:0]       pause_end_reg;
    logic                              started_reg;
    logic                              pausing_reg;

    logic                              out_valid_reg;
    logic                              skid_valid_reg;
    pslb_pkg::result_t                 out_reg;
    pslb_pkg::result_t                 skid_reg;

    logic [pslb_pkg::NUM_FLAGS-1:0]    event_flags_next;
    logic                              pulse_next;
    logic                              lamp_on_next;
    logic [pslb_pkg::TIME_W-1:0]       last_toggle_next;
    logic [pslb_pkg::FLASH_W-1:0]      flash_count_next;
    logic [pslb_pkg::TIME_W-1:0]       pause_end_next;
    logic                              started_next;
    logic                              pausing_next;

    pslb_pkg::event_t                  sel;
    logic                              has;
    logic                              run;
    logic                              write;
    logic                              lit;
    logic                              toggle;
    logic [pslb_pkg::TIME_W-1:0]       elapsed;
    logic [pslb_pkg::PHASE_W-1:0]      phase_ms;
    logic [pslb_pkg::FLASH_W:0]        flash_inc;
    pslb_pkg::pattern_t                pat;
    pslb_pkg::pattern_t                shown_pat;
    pslb_pkg::result_t                 res;
    logic                              advance;
    logic                              out_take;

    assign advance  = in_valid_reg && !skid_valid_reg;
    assign s_ready  = !in_valid_reg || !skid_valid_reg;
    assign out_take = out_valid_reg && m_ready;

    always_comb begin
        event_flags_next = event_flags_reg;
        pulse_next       = pulse_reg;
        case (pslb_pkg::command_t'(in_command_reg))
            pslb_pkg::CMD_START: begin
                if (!in_code_reg[pslb_pkg::EVENT_W-1]) begin
                    event_flags_next[in_code_reg[pslb_pkg::EVENT_W-2:0]] = 1'b1;
                end
            end
            pslb_pkg::CMD_STOP: begin
                if (!in_code_reg[pslb_pkg::EVENT_W-1]) begin
                    event_flags_next[in_code_reg[pslb_pkg::EVENT_W-2:0]] = 1'b0;
                end
            end
            pslb_pkg::CMD_PULSE: begin
                if (in_code_reg == pslb_pkg::NO_EVENT) begin
                    pulse_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        sel = pslb_pkg::NO_EVENT;
        for (int i = pslb_pkg::NUM_FLAGS - 1; i >= 0; i--) begin
            if (event_flags_next[i]) begin
                sel = pslb_pkg::event_t'(i);
            end
        end
        has = (|event_flags_next) || pulse_next;
        run = (pslb_pkg::command_t'(in_command_reg) == pslb_pkg::CMD_TICK) && has;
        pat = pslb_pkg::blink_pattern(sel);

        // A change of the selected event restarts the blink sequence.
        if (sel != shown_event_reg) begin
            lamp_on_next     = 1'b0;
            last_toggle_next = '0;
            flash_count_next = '0;
            pause_end_next   = '0;
            started_next     = 1'b0;
            pausing_next     = 1'b0;
        end else begin
            lamp_on_next     = lamp_on_reg;
            last_toggle_next = last_toggle_reg;
            flash_count_next = flash_count_reg;
            pause_end_next   = pause_end_reg;
            started_next     = started_reg;
            pausing_next     = pausing_reg;
        end

        write     = 1'b0;
        lit       = 1'b0;
        toggle    = 1'b0;
        elapsed   = in_now_reg - last_toggle_next;
        phase_ms  = lamp_on_next ? pat.on_ms : pat.off_ms;
        flash_inc = {1'b0, flash_count_next} + (pslb_pkg::FLASH_W+1)'(1);

        if (pausing_next && (in_now_reg - pause_end_next) >> (pslb_pkg::TIME_W - 1) != 0) begin
            write = 1'b1;
        end else begin
            if (pausing_next) begin
                pausing_next   = 1'b0;
                pause_end_next = '0;
                started_next   = 1'b0;
            end
            toggle = !started_next || elapsed >= pslb_pkg::TIME_W'(phase_ms);
            if (toggle) begin
                write            = 1'b1;
                lamp_on_next     = !lamp_on_next;
                last_toggle_next = in_now_reg;
                started_next     = 1'b1;
                if (lamp_on_next) begin
                    lit = 1'b1;
                end else if (flash_inc >= {1'b0, pat.flashes}) begin
                    flash_count_next = '0;
                    if (pat.repeat_en) begin
                        if (pat.pause_ms != '0) begin
                            pause_end_next = in_now_reg + pslb_pkg::TIME_W'(pat.pause_ms);
                            pausing_next   = 1'b1;
                        end
                    end else if (run) begin
                        pulse_next = 1'b0;
                    end
                end else begin
                    flash_count_next = flash_inc[pslb_pkg::FLASH_W-1:0];
                end
            end
        end

        res.has_event     = has;
        res.current_event = has ? sel : pslb_pkg::NO_EVENT;
        res.color_write   = run && write;
        res.red_out       = (run && lit) ? pslb_pkg::scale_channel(pat.red, scale_reg)   : '0;
        res.green_out     = (run && lit) ? pslb_pkg::scale_channel(pat.green, scale_reg) : '0;
        res.blue_out      = (run && lit) ? pslb_pkg::scale_channel(pat.blue, scale_reg)  : '0;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_code_reg    <= s_event_code;
            in_now_reg     <= s_now_ms;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= pslb_pkg::SCALE_RESET;
        end else if (cfg_we) begin
            scale_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_flags_reg <= '0;
            pulse_reg       <= 1'b0;
            shown_event_reg <= pslb_pkg::NO_EVENT;
            lamp_on_reg     <= 1'b0;
            last_toggle_reg <= '0;
            flash_count_reg <= '0;
            pause_end_reg   <= '0;
            started_reg     <= 1'b0;
            pausing_reg     <= 1'b0;
        end else if (advance) begin
            event_flags_reg <= event_flags_next;
            pulse_reg       <= pulse_next;
            if (run) begin
                shown_event_reg <= sel;
                lamp_on_reg     <= lamp_on_next;
                last_toggle_reg <= last_toggle_next;
                flash_count_reg <= flash_count_next;
                pause_end_reg   <= pause_end_next;
                started_reg     <= started_next;
                pausing_reg     <= pausing_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            if (!out_valid_reg || out_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (!out_valid_reg || out_take) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end else if (out_take && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_has_event     = out_reg.has_event;
    assign m_current_event = out_reg.current_event;
    assign m_color_write   = out_reg.color_write;
    assign m_red_out       = out_reg.red_out;
    assign m_green_out     = out_reg.green_out;
    assign m_blue_out      = out_reg.blue_out;

    assign shown_pat = pslb_pkg::blink_pattern(shown_event_reg);

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    a_write_needs_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_color_write) |-> m_has_event)
        else $error("Color write reported with no active event.");

    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_event) |-> (m_current_event == pslb_pkg::NO_EVENT
            && !m_color_write && m_red_out == '0 && m_green_out == '0 && m_blue_out == '0))
        else $error("Inactive result carries an event or a color.");

    a_flash_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, flash_count_reg} < {1'b0, shown_pat.flashes})
        else $error("Flash count reached the pattern's flash total.");

    a_pause_started: assert property (@(posedge aclk) disable iff (!aresetn)
        pausing_reg |-> started_reg)
        else $error("Pause running with the blink timer unstarted.");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        pslb_pkg::command_t cmd;
        pslb_pkg::event_t   code;
        logic [31:0]        now;
    } led_req_t;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        logic [7:0]  flashes;
        logic [31:0] pause_ms;
        logic        repeat_on;
    } blink_shape_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [3:0]  s_event_code = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_has_event;
    logic [3:0]  m_current_event;
    logic        m_color_write;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;

    led_req_t           pending_q[$];
    pslb_pkg::result_t  expected_q[$];
    led_req_t    tx_cur;
    logic        tx_live = 1'b0;
    int unsigned tx_gap = 0;
    logic        rx_ready = 1'b0;
    int unsigned rx_stall = 0;
    int unsigned hold_left = 0;
    logic        hold_arm = 1'b0;
    logic        steady = 1'b0;
    int unsigned mismatch_count = 0;
    logic [31:0] clock_ms = '0;
    logic [7:0]  plan_flags = '0;

    // Predicted block state.
    logic [7:0]        scale_r = 8'd13;
    logic [7:0]        flags_r = '0;
    logic              pulse_r = 1'b0;
    pslb_pkg::event_t  shown_r = pslb_pkg::NO_EVENT;
    logic              lit_r = 1'b0;
    logic [31:0]       toggle_t = '0;
    logic [7:0]        flash_n = '0;
    logic [31:0]       pause_end = '0;
    logic              started_r = 1'b0;
    logic              pausing_r = 1'b0;

    priority_status_led_blinker u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_event_code    (s_event_code),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_has_event     (m_has_event),
        .m_current_event (m_current_event),
        .m_color_write   (m_color_write),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out)
    );

    function automatic blink_shape_t shape_of(input pslb_pkg::event_t ev);
        case (ev)
            4'd0:    return '{8'd0,   8'd120, 8'd255, 120,  880,  8'd2, 5000,  1'b1};
            4'd1:    return '{8'd160, 8'd0,   8'd200, 250,  250,  8'd2, 2000,  1'b1};
            4'd2:    return '{8'd255, 8'd80,  8'd0,   200,  200,  8'd1, 5000,  1'b1};
            4'd3:    return '{8'd255, 8'd255, 8'd255, 100,  100,  8'd2, 1000,  1'b1};
            4'd4:    return '{8'd0,   8'd120, 8'd255, 100,  100,  8'd2, 1000,  1'b1};
            4'd5:    return '{8'd140, 8'd0,   8'd255, 1000, 1000, 8'd1, 0,     1'b1};
            4'd6:    return '{8'd255, 8'd140, 8'd0,   150,  150,  8'd3, 10000, 1'b1};
            4'd7:    return '{8'd0,   8'd80,  8'd255, 150,  150,  8'd1, 30000, 1'b1};
            default: return '{8'd0,   8'd200, 8'd200, 150,  150,  8'd2, 0,     1'b0};
        endcase
    endfunction

    function automatic logic [7:0] dim_channel(input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'(scale_r);
        return 8'(prod / 16'd255);
    endfunction

    function automatic pslb_pkg::result_t predict_blink(input led_req_t rq);
        pslb_pkg::result_t res;
        blink_shape_t      shp;
        pslb_pkg::event_t  pick;
        logic              busy;
        logic [31:0]       span;
        int                i;
        res = '0;
        case (rq.cmd)
            pslb_pkg::CMD_START: if (!rq.code[3]) flags_r[rq.code[2:0]] = 1'b1;
            pslb_pkg::CMD_STOP:  if (!rq.code[3]) flags_r[rq.code[2:0]] = 1'b0;
            pslb_pkg::CMD_PULSE: if (rq.code == pslb_pkg::NO_EVENT) pulse_r = 1'b1;
            default: ;
        endcase
        pick = pslb_pkg::NO_EVENT;
        for (i = 7; i >= 0; i--) begin
            if (flags_r[i]) pick = pslb_pkg::event_t'(i);
        end
        busy = (flags_r != '0) || pulse_r;
        res.has_event = busy;
        res.current_event = pick;
        if (rq.cmd == pslb_pkg::CMD_TICK && busy) begin
            if (pick != shown_r) begin
                shown_r = pick;
                lit_r = 1'b0;
                toggle_t = '0;
                flash_n = '0;
                pause_end = '0;
                started_r = 1'b0;
                pausing_r = 1'b0;
            end
            shp = shape_of(pick);
            span = rq.now - pause_end;
            if (pausing_r && span[31]) begin
                res.color_write = 1'b1;
            end else begin
                if (pausing_r) begin
                    pausing_r = 1'b0;
                    pause_end = '0;
                    started_r = 1'b0;
                end
                span = rq.now - toggle_t;
                if (!started_r || span >= (lit_r ? shp.on_ms : shp.off_ms)) begin
                    res.color_write = 1'b1;
                    lit_r = !lit_r;
                    toggle_t = rq.now;
                    started_r = 1'b1;
                    if (lit_r) begin
                        res.red_out = dim_channel(shp.red);
                        res.green_out = dim_channel(shp.green);
                        res.blue_out = dim_channel(shp.blue);
                    end else begin
                        flash_n = flash_n + 8'd1;
                        if (flash_n >= shp.flashes) begin
                            flash_n = '0;
                            if (!shp.repeat_on) begin
                                pulse_r = 1'b0;
                            end else if (shp.pause_ms != 0) begin
                                pause_end = rq.now + shp.pause_ms;
                                pausing_r = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    task automatic add_req(input pslb_pkg::command_t c, input pslb_pkg::event_t e,
                           input logic [31:0] t);
        led_req_t rq;
        rq.cmd = c;
        rq.code = e;
        rq.now = t;
        pending_q.insert(pending_q.size(), rq);
    endtask

    task automatic add_flag(input pslb_pkg::command_t c, input pslb_pkg::event_t e);
        if (!e[3] && c == pslb_pkg::CMD_START) plan_flags[e[2:0]] = 1'b1;
        if (!e[3] && c == pslb_pkg::CMD_STOP) plan_flags[e[2:0]] = 1'b0;
        add_req(c, e, $urandom);
    endtask

    task automatic add_tick();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) clock_ms += $urandom_range(0, 300);
        else if (r < 85) clock_ms += $urandom_range(300, 1200);
        else if (r < 97) clock_ms += $urandom_range(1000, 35000);
        else clock_ms = $urandom;
        add_req(pslb_pkg::CMD_TICK, pslb_pkg::event_t'($urandom_range(0, 15)), clock_ms);
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 3) == 0)
            add_flag(pslb_pkg::command_t'($urandom_range(1, 3)),
                     pslb_pkg::event_t'($urandom_range(8, 15)));
        else
            add_flag(pslb_pkg::command_t'($urandom_range(1, 3)),
                     pslb_pkg::event_t'($urandom_range(0, 7)));
    endtask

    task automatic add_episode();
        int unsigned kind;
        int unsigned n;
        int unsigned i;
        kind = $urandom_range(0, 9);
        n = $urandom_range(6, 40);
        if (kind < 8) begin
            for (i = 0; i < 8; i++) begin
                if (plan_flags[i]) add_flag(pslb_pkg::CMD_STOP, pslb_pkg::event_t'(i));
            end
            if (kind < 6) begin
                add_flag(pslb_pkg::CMD_START, pslb_pkg::event_t'($urandom_range(0, 7)));
                if ($urandom_range(0, 2) == 0)
                    add_flag(pslb_pkg::CMD_START, pslb_pkg::event_t'($urandom_range(0, 7)));
            end else begin
                add_flag(pslb_pkg::CMD_PULSE, pslb_pkg::NO_EVENT);
            end
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) add_noise();
                else add_tick();
            end
        end else begin
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) == 0) add_tick();
                else add_noise();
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || tx_live || expected_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_scale(input logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        scale_r = v;
    endtask

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (tx_live && s_ready) begin
                expected_q.insert(expected_q.size(), predict_blink(tx_cur));
                tx_live = 1'b0;
            end
            if (!tx_live) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (pending_q.size() != 0) begin
                    tx_cur = pending_q.pop_front();
                    s_command <= tx_cur.cmd;
                    s_event_code <= tx_cur.code;
                    s_now_ms <= tx_cur.now;
                    tx_live = 1'b1;
                    tx_gap = steady ? 0 : pick_gap();
                end
            end
            s_valid <= tx_live;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) hold_left <= 0;
        else if (hold_arm) hold_left <= 400;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin : rx_proc
        pslb_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && rx_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: has=%0b ev=%0d wr=%0b rgb=%0d/%0d/%0d",
                                 m_has_event, m_current_event, m_color_write,
                                 m_red_out, m_green_out, m_blue_out);
                end else begin
                    want = expected_q.pop_front();
                    if (m_has_event !== want.has_event
                            || m_current_event !== want.current_event
                            || m_color_write !== want.color_write
                            || m_red_out !== want.red_out
                            || m_green_out !== want.green_out
                            || m_blue_out !== want.blue_out) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("mismatch: expected has=%0b ev=%0d wr=%0b rgb=%0d/%0d/%0d,",
                                   want.has_event, want.current_event, want.color_write,
                                   want.red_out, want.green_out, want.blue_out);
                            $display(" got has=%0b ev=%0d wr=%0b rgb=%0d/%0d/%0d",
                                     m_has_event, m_current_event, m_color_write,
                                     m_red_out, m_green_out, m_blue_out);
                        end
                    end
                end
            end
            if (hold_arm || hold_left != 0) begin
                rx_ready = 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                rx_ready = 1'b0;
            end else begin
                rx_ready = 1'b1;
                rx_stall = steady ? 0 : pick_gap();
            end
            m_ready <= rx_ready;
        end
    end

    initial begin : main_seq
        int unsigned ph;
        logic [7:0]  scale_v;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Nothing active, then ignored codes, then the one-shot firmware check across the wrap.
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd0);
        add_flag(pslb_pkg::CMD_START, 4'd15);
        add_flag(pslb_pkg::CMD_STOP, 4'd9);
        add_flag(pslb_pkg::CMD_PULSE, 4'd3);
        add_flag(pslb_pkg::CMD_PULSE, pslb_pkg::NO_EVENT);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'hFFFF_FF00);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'hFFFF_FF95);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'hFFFF_FF96);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'h0000_002C);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'h0000_00C2);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'h0000_0100);
        // Priority, a full flash group into a pause, and a change of selection.
        add_flag(pslb_pkg::CMD_START, 4'd7);
        add_flag(pslb_pkg::CMD_START, 4'd0);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd1000);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd1120);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd2000);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd2120);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd3000);
        add_flag(pslb_pkg::CMD_STOP, 4'd0);
        add_req(pslb_pkg::CMD_TICK, 4'd0, 32'd7200);
        add_flag(pslb_pkg::CMD_START, 4'd3);
        add_flag(pslb_pkg::CMD_STOP, 4'd3);
        add_flag(pslb_pkg::CMD_STOP, 4'd7);
        add_req(pslb_pkg::CMD_TICK, 4'hF, 32'hFFFF_FFFF);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: scale_v = 8'd255;
                1: scale_v = 8'd0;
                2: scale_v = 8'd1;
                4: scale_v = 8'd254;
                default: scale_v = 8'($urandom_range(2, 253));
            endcase
            write_scale(scale_v);
            @(negedge aclk);
            while (pending_q.size() < 350) add_episode();
            if (ph == 1) begin
                @(posedge aclk);
                hold_arm <= 1'b1;
                @(posedge aclk);
                hold_arm <= 1'b0;
            end
            if (ph == 3) begin
                @(posedge aclk);
                steady <= 1'b1;
            end
            wait_drained();
            @(posedge aclk);
            steady <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
